// File: sv/mcpid_pkg.sv
// Shared types, constants and saturating helpers for the multi-channel PID block.
// No dependencies; imported by mcpid_ctrl, mcpid_dp and the top level.
`timescale 1ns / 1ps
`default_nettype none

package mcpid_pkg;

	localparam int LEGS_DEF      = 4;
	localparam int FRAC_BITS_DEF = 16;
	localparam int AXES          = 3;

	localparam int DATA_W    = 32;
	localparam int GAIN_W    = 31;
	localparam int LEG_W     = 2;
	localparam int AXIS_W    = 2;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_SCALE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_POLE  = 3'd5;

	localparam logic [GAIN_W-1:0]        PROP_GAIN_RST   = 31'd65536000;
	localparam logic [GAIN_W-1:0]        INTEG_GAIN_RST  = 31'd0;
	localparam logic [GAIN_W-1:0]        DERIV_GAIN_RST  = 31'd1310720;
	localparam logic [GAIN_W-1:0]        HALF_PERIOD_RST = 31'd33;
	localparam logic [GAIN_W-1:0]        DERIV_SCALE_RST = 31'd23627694;
	localparam logic signed [DATA_W-1:0] DERIV_POLE_RST  = -32'sd41907;

	localparam logic [AXIS_W-1:0] LAST_AXIS = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_FIX,
		ST_WRITE,
		ST_FINISH
	} state_t;

	typedef enum logic [2:0] {
		OP_P,
		OP_IH,
		OP_IK,
		OP_DS,
		OP_DK,
		OP_DP
	} op_t;

	typedef struct packed {
		logic              capture;
		logic              load;
		logic              mul;
		logic              fix;
		logic              write;
		logic              finish;
		op_t               op;
		logic [AXIS_W-1:0] axis;
	} dp_cmd_t;

	localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
	localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

	function automatic logic signed [DATA_W-1:0] sat64(input logic signed [63:0] v);
		if (v > SAT_MAX)
			return 32'sh7fffffff;
		else if (v < SAT_MIN)
			return 32'sh80000000;
		else
			return signed'(v[DATA_W-1:0]);
	endfunction

	function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] s);
		if (s[DATA_W] != s[DATA_W-1])
			return s[DATA_W] ? 32'sh80000000 : 32'sh7fffffff;
		else
			return signed'(s[DATA_W-1:0]);
	endfunction

	function automatic logic signed [DATA_W-1:0] add_sat(
		input logic signed [DATA_W-1:0] a,
		input logic signed [DATA_W-1:0] b
	);
		return sat33(33'(a) + 33'(b));
	endfunction

	function automatic logic signed [DATA_W-1:0] sub_sat(
		input logic signed [DATA_W-1:0] a,
		input logic signed [DATA_W-1:0] b
	);
		return sat33(33'(a) - 33'(b));
	endfunction

	// fold a channel code into range by repeated subtraction
	function automatic logic [LEG_W-1:0] leg_fold(input logic [LEG_W-1:0] v, input int legs);
		logic [LEG_W-1:0] r;
		r = v;
		for (int k = 0; k < 3; k++) begin
			if (int'(r) >= legs)
				r = r - LEG_W'(legs);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: sv/mcpid_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mcpid_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 12
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[wr_addr] <= wr_data;
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// File: sv/mcpid_ctrl.sv
// Controller: sequences load, six multiplies per axis, write-back and output hand-off.
// Depends on mcpid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcpid_ctrl import mcpid_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  wire logic out_stall,
	output dp_cmd_t   cmd
);

	state_t            state_q, state_d;
	op_t               op_q, op_d;
	logic [AXIS_W-1:0] axis_q, axis_d;
	logic              out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_P;
			axis_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			op_q        <= op_d;
			axis_q      <= axis_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		op_d        = op_q;
		axis_d      = axis_q;
		out_valid_d = out_valid_q && out_stall;
		cmd         = '0;
		cmd.op      = op_q;
		cmd.axis    = axis_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					axis_d      = '0;
					state_d     = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				op_d     = OP_P;
				state_d  = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_FIX;
			end
			ST_FIX: begin
				cmd.fix = 1'b1;
				unique case (op_q)
					OP_P:    op_d = OP_IH;
					OP_IH:   op_d = OP_IK;
					OP_IK:   op_d = OP_DS;
					OP_DS:   op_d = OP_DK;
					OP_DK:   op_d = OP_DP;
					default: op_d = OP_P;
				endcase
				state_d = (op_q == OP_DP) ? ST_WRITE : ST_MUL;
			end
			ST_WRITE: begin
				cmd.write = 1'b1;
				if (axis_q == LAST_AXIS) begin
					state_d = ST_FINISH;
				end else begin
					axis_d  = axis_q + AXIS_W'(1);
					state_d = ST_LOAD;
				end
			end
			ST_FINISH: begin
				// hold until the previous item has left the output register
				if (!out_valid_q || !out_stall) begin
					cmd.finish  = 1'b1;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// File: sv/mcpid_dp.sv
// Datapath: configuration registers, input capture, shared 32x32 multiplier,
// saturation, integral/derivative stores with valid bits, output registers.
// Depends on mcpid_pkg and mcpid_ram.
`timescale 1ns / 1ps
`default_nettype none

module mcpid_dp import mcpid_pkg::*; #(
	parameter int LEGS      = LEGS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire dp_cmd_t                     cmd,
	input  wire logic                        cfg_we,
	input  wire logic [CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [DATA_W-1:0]           cfg_data,
	input  wire logic [LEG_W-1:0]            leg_index,
	input  wire logic signed [DATA_W-1:0]    err_x,
	input  wire logic signed [DATA_W-1:0]    err_y,
	input  wire logic signed [DATA_W-1:0]    err_z,
	input  wire logic signed [DATA_W-1:0]    prev_err_x,
	input  wire logic signed [DATA_W-1:0]    prev_err_y,
	input  wire logic signed [DATA_W-1:0]    prev_err_z,
	output logic signed [DATA_W-1:0]         drive_x,
	output logic signed [DATA_W-1:0]         drive_y,
	output logic signed [DATA_W-1:0]         drive_z
);

	localparam int DEPTH  = LEGS * AXES;
	localparam int SLOT_W = $clog2(DEPTH);

	logic [GAIN_W-1:0]        kp_q, ki_q, kd_q, h_q, s_q;
	logic signed [DATA_W-1:0] pole_q;

	logic [LEG_W-1:0]         leg_q;
	logic signed [DATA_W-1:0] err_q [AXES];
	logic signed [DATA_W-1:0] perr_q [AXES];
	logic signed [DATA_W-1:0] sum_q, diff_q;
	logic [SLOT_W-1:0]        slot_q, slot_d;
	logic [DEPTH-1:0]         valid_q;

	logic signed [DATA_W-1:0] op_a, op_b, fres;
	logic signed [63:0]       prod_s1;
	logic signed [DATA_W-1:0] t_q, p_q, i_q, u_q, d_q;
	logic signed [DATA_W-1:0] tot_q [AXES];

	logic [DATA_W-1:0]        irdata, drdata;
	logic signed [DATA_W-1:0] iprev, dprev;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q   <= PROP_GAIN_RST;
			ki_q   <= INTEG_GAIN_RST;
			kd_q   <= DERIV_GAIN_RST;
			h_q    <= HALF_PERIOD_RST;
			s_q    <= DERIV_SCALE_RST;
			pole_q <= DERIV_POLE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PROP_GAIN:   kp_q   <= cfg_data[GAIN_W-1:0];
				REG_INTEG_GAIN:  ki_q   <= cfg_data[GAIN_W-1:0];
				REG_DERIV_GAIN:  kd_q   <= cfg_data[GAIN_W-1:0];
				REG_HALF_PERIOD: h_q    <= cfg_data[GAIN_W-1:0];
				REG_DERIV_SCALE: s_q    <= cfg_data[GAIN_W-1:0];
				REG_DERIV_POLE:  pole_q <= signed'(cfg_data);
				default: ;
			endcase
		end
	end

	assign slot_d = SLOT_W'(leg_q) * SLOT_W'(AXES) + SLOT_W'(cmd.axis);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= '0;
		else if (cmd.write)
			valid_q[slot_q] <= 1'b1;
	end

	assign iprev = valid_q[slot_q] ? signed'(irdata) : '0;
	assign dprev = valid_q[slot_q] ? signed'(drdata) : '0;

	always_comb begin
		case (cmd.op)
			OP_P: begin
				op_a = signed'({1'b0, kp_q});
				op_b = err_q[cmd.axis];
			end
			OP_IH: begin
				op_a = signed'({1'b0, h_q});
				op_b = sum_q;
			end
			OP_IK: begin
				op_a = signed'({1'b0, ki_q});
				op_b = t_q;
			end
			OP_DS: begin
				op_a = signed'({1'b0, s_q});
				op_b = diff_q;
			end
			OP_DK: begin
				op_a = signed'({1'b0, kd_q});
				op_b = t_q;
			end
			default: begin
				op_a = pole_q;
				op_b = dprev;
			end
		endcase
	end

	// arithmetic shift gives the floor of the scaled product
	assign fres = sat64(prod_s1 >>> FRAC_BITS);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			leg_q     <= leg_fold(leg_index, LEGS);
			err_q[0]  <= err_x;
			err_q[1]  <= err_y;
			err_q[2]  <= err_z;
			perr_q[0] <= prev_err_x;
			perr_q[1] <= prev_err_y;
			perr_q[2] <= prev_err_z;
		end
		if (cmd.load) begin
			sum_q  <= add_sat(err_q[cmd.axis], perr_q[cmd.axis]);
			diff_q <= sub_sat(err_q[cmd.axis], perr_q[cmd.axis]);
			slot_q <= slot_d;
		end
		if (cmd.mul)
			prod_s1 <= 64'(op_a) * 64'(op_b);
		if (cmd.fix) begin
			case (cmd.op)
				OP_P:    p_q <= fres;
				OP_IH:   t_q <= fres;
				OP_IK:   i_q <= add_sat(fres, iprev);
				OP_DS:   t_q <= fres;
				OP_DK:   u_q <= fres;
				default: d_q <= sub_sat(u_q, fres);
			endcase
		end
		if (cmd.write)
			tot_q[cmd.axis] <= add_sat(add_sat(p_q, i_q), d_q);
		if (cmd.finish) begin
			drive_x <= tot_q[0];
			drive_y <= tot_q[1];
			drive_z <= tot_q[2];
		end
	end

	mcpid_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_integ_ram (
		.clk    (clk),
		.we     (cmd.write),
		.wr_addr(slot_q),
		.wr_data(i_q),
		.rd_addr(slot_q),
		.rd_data(irdata)
	);

	mcpid_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_deriv_ram (
		.clk    (clk),
		.we     (cmd.write),
		.wr_addr(slot_q),
		.wr_data(d_q),
		.rd_addr(slot_q),
		.rd_data(drdata)
	);

endmodule

`default_nettype wire

// File: sv/multi_channel_pid_filtered_derivative.sv
// Top level of the multi-channel three-axis PID step with filtered derivative.
// Depends on mcpid_pkg, mcpid_ctrl, mcpid_dp (and mcpid_ram through mcpid_dp).
//
//   channel  handshake              payload
//   in       in_valid / in_stall    leg_index, err_x/y/z, prev_err_x/y/z
//   out      out_valid / out_stall  drive_x, drive_y, drive_z
//   cfg      cfg_we                 cfg_index, cfg_data
//
// Per item: accept, then per axis a load step, six multiplies (each a multiply and a fix step)
// through the single shared 32x32 multiplier, and a write-back step, then the hand-off.
// Stores are valid-bit masked, so reset needs no clearing pass.
// The output register holds a finished item while the next one is computed; hand-off
// of the next item waits while out_stall holds the previous one.
`timescale 1ns / 1ps
`default_nettype none

module multi_channel_pid_filtered_derivative import mcpid_pkg::*; #(
	parameter int LEGS      = LEGS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [DATA_W-1:0]        cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [LEG_W-1:0]         leg_index,
	input  wire logic signed [DATA_W-1:0] err_x,
	input  wire logic signed [DATA_W-1:0] err_y,
	input  wire logic signed [DATA_W-1:0] err_z,
	input  wire logic signed [DATA_W-1:0] prev_err_x,
	input  wire logic signed [DATA_W-1:0] prev_err_y,
	input  wire logic signed [DATA_W-1:0] prev_err_z,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [DATA_W-1:0]      drive_x,
	output logic signed [DATA_W-1:0]      drive_y,
	output logic signed [DATA_W-1:0]      drive_z
);

	dp_cmd_t cmd;

	mcpid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd)
	);

	mcpid_dp #(
		.LEGS     (LEGS),
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.leg_index (leg_index),
		.err_x     (err_x),
		.err_y     (err_y),
		.err_z     (err_z),
		.prev_err_x(prev_err_x),
		.prev_err_y(prev_err_y),
		.prev_err_z(prev_err_z),
		.drive_x   (drive_x),
		.drive_y   (drive_y),
		.drive_z   (drive_z)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after an accepted item");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without an item in progress");

	a_handoff_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid || !out_stall))
		else $error("output register overwritten while stalled");

endmodule

`default_nettype wire
